### rtl/sfs_pkg.sv
// Shared types and constants for the scan FIR smoother.
// Used by sfs_mac, scan_fir_smoother_core and the testbench; no dependencies.
package sfs_pkg;

   localparam int TAP_W      = 3;   // tap_count register width
   localparam int COEF_W     = 16;  // signed Q1.15 weights
   localparam int NUM_COEF   = 7;
   localparam int COEF_IDX_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int FRAC_BITS  = 15;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BASE = 3'd1;

   localparam logic [TAP_W-1:0]         TAP_COUNT_RST = 3'd1;
   localparam logic signed [COEF_W-1:0] COEF0_RST     = 16'sd32767;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FILT,
      ST_RAW,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic clear;   // zero the accumulator
      logic issue;   // multiply the presented sample and weight
   } mac_ctrl_type;

endpackage

### rtl/sfs_mac.sv
// Shared multiply-accumulate unit with round, shift and saturate on the sum.
// Depends on sfs_pkg.
module sfs_mac #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_TAPS    = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sfs_pkg::mac_ctrl_type            ctrl,
   input  logic [SAMPLE_BITS-1:0]           sample,
   input  logic signed [sfs_pkg::COEF_W-1:0] coef,
   output logic [SAMPLE_BITS-1:0]           result
);

   localparam int PROD_W = SAMPLE_BITS + 1 + sfs_pkg::COEF_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
   localparam int TOP_LO = sfs_pkg::FRAC_BITS + SAMPLE_BITS;

   logic signed [SAMPLE_BITS:0] samp_s;
   logic signed [PROD_W-1:0]    prod_in, prod_ff;
   logic                        prod_vld_ff;
   logic signed [ACC_W-1:0]     acc_in, acc_ff;
   logic signed [ACC_W:0]       rnd;

   assign samp_s  = {1'b0, sample};
   assign prod_in = samp_s * coef;

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= ctrl.issue & ~ctrl.clear;
         acc_ff      <= acc_in;
      end
      prod_ff <= prod_in;
   end

   // Round half up, drop the fraction, clamp to the sample range.
   assign rnd = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(sfs_pkg::ROUND_HALF);

   always_comb begin
      if (rnd[ACC_W]) begin
         result = '0;
      end else if (rnd[ACC_W-1:TOP_LO] != '0) begin
         result = '1;
      end else begin
         result = rnd[TOP_LO-1:sfs_pkg::FRAC_BITS];
      end
   end

endmodule

### rtl/scan_fir_smoother_core.sv
// Top level of the scan FIR smoother: register file, sample window and sequencer.
// Depends on sfs_pkg and sfs_mac.
//
// Usage:
//  - req_* carries one range item per handshake (valid/ready); req_scan_end marks
//    the final sample of a scan. rsp_* returns range items in scan order with
//    was_filtered and scan_last flags. csr_* writes tap_count (index 0) and
//    coef_0..coef_6 (indices 1..7); write only while the block is idle.
//  - Output lags input by half the odd tap count T. The first and last T/2 samples
//    of a scan, and every sample of a scan shorter than T, pass through raw.
//  - One item at a time. A filtered item runs one multiply per tap on the single
//    shared multiply-accumulate unit, then drains its product register, then rounds
//    and loads the output register, and the sequencer goes idle for the next accept.
//    A raw item loads the output register straight from the window; a scan-end item
//    adds one flush step per tail item (at most 3 more).
//  - The output register holds each result until rsp_ready; while it is full the
//    sequencer waits, so a stalled receiver stalls req_ready as well.
//  - Synchronous reset empties the window and the output register, sets
//    tap_count to 1, coef_0 to 32767 and the other weights to 0.
module scan_fir_smoother_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_TAPS    = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   // input items
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [SAMPLE_BITS-1:0]             req_range_in,
   input  logic                               req_scan_end,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [SAMPLE_BITS-1:0]             rsp_range_out,
   output logic                               rsp_was_filtered,
   output logic                               rsp_scan_last,
   // register writes
   input  logic                               csr_wr_en,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_TAPS + 1);
   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   // ---------------------------------------------------------------- registers
   logic [sfs_pkg::TAP_W-1:0]         tap_count_ff;
   logic signed [sfs_pkg::COEF_W-1:0] coef_ff [sfs_pkg::NUM_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= sfs_pkg::TAP_COUNT_RST;
         for (int i = 1; i < sfs_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[0] <= sfs_pkg::COEF0_RST;
      end else if (csr_wr_en) begin
         if (csr_index == sfs_pkg::CSR_TAP_COUNT) begin
            tap_count_ff <= csr_wr_data[sfs_pkg::TAP_W-1:0];
         end else begin
            coef_ff[sfs_pkg::COEF_IDX_W'(csr_index - sfs_pkg::CSR_COEF_BASE)] <= csr_wr_data;
         end
      end
   end

   // Effective odd tap count and half width.
   logic [CNT_W-1:0] t_lim, t_eff, h_eff;

   always_comb begin
      if (int'(tap_count_ff) > MAX_TAPS) begin
         t_lim = CNT_W'(MAX_TAPS);
      end else begin
         t_lim = CNT_W'(tap_count_ff);
      end
      if (t_lim[0]) begin
         t_eff = t_lim;
      end else if (t_lim == '0) begin
         t_eff = CNT_W'(1);
      end else begin
         t_eff = t_lim - CNT_W'(1);
      end
      h_eff = t_eff >> 1;
   end

   // ---------------------------------------------------------------- state
   sfs_pkg::state_type state_ff, state_in;
   logic [SAMPLE_BITS-1:0] window_ff [MAX_TAPS];
   logic [CNT_W-1:0]       fill_count_ff, fill_count_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;     // tap being multiplied
   logic [IDX_W-1:0]       a_ff, a_in;         // window entry of the next tail item
   logic                   end_ff;
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_range_ff;
   logic                   rsp_filt_ff, rsp_last_ff;

   logic                   accept, out_free, out_load;
   logic [SAMPLE_BITS-1:0] out_range;
   logic                   out_filt, out_last;
   logic [IDX_W-1:0]       rd_addr;
   logic [SAMPLE_BITS-1:0] win_rd;
   logic [SAMPLE_BITS-1:0] mac_result;
   sfs_pkg::mac_ctrl_type  mac_ctrl;
   logic                   k_ge_h, k_filt, idx_last;

   assign accept   = req_valid & req_ready;
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign k_ge_h   = fill_count_ff >= h_eff;
   assign k_filt   = ({1'b0, fill_count_ff} + (CNT_W+1)'(1)) >= {1'b0, t_eff};
   assign idx_last = CNT_W'(idx_ff) == (t_eff - CNT_W'(1));
   assign win_rd   = window_ff[rd_addr];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfs_pkg::ST_IDLE: begin
            if (accept) begin
               if (k_ge_h) begin
                  state_in = k_filt ? sfs_pkg::ST_MAC : sfs_pkg::ST_RAW;
               end else if (req_scan_end) begin
                  state_in = sfs_pkg::ST_FLUSH;
               end
            end
         end
         sfs_pkg::ST_MAC: begin
            if (idx_last) begin
               state_in = sfs_pkg::ST_DRAIN;
            end
         end
         sfs_pkg::ST_DRAIN: begin
            state_in = sfs_pkg::ST_FILT;
         end
         sfs_pkg::ST_FILT, sfs_pkg::ST_RAW: begin
            if (out_free) begin
               state_in = (end_ff && h_eff != '0) ? sfs_pkg::ST_FLUSH : sfs_pkg::ST_IDLE;
            end
         end
         sfs_pkg::ST_FLUSH: begin
            if (out_free && a_ff == '0) begin
               state_in = sfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfs_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      mac_ctrl  = '0;
      out_load  = 1'b0;
      out_range = win_rd;
      out_filt  = 1'b0;
      out_last  = 1'b0;
      rd_addr   = a_ff;
      case (state_ff)
         sfs_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            mac_ctrl.clear = 1'b1;
         end
         sfs_pkg::ST_MAC: begin
            // tap i weights the entry t-1-i, oldest sample on tap 0
            mac_ctrl.issue = 1'b1;
            rd_addr        = IDX_W'(t_eff - CNT_W'(1) - CNT_W'(idx_ff));
         end
         sfs_pkg::ST_DRAIN: begin
            rd_addr = a_ff;
         end
         sfs_pkg::ST_FILT: begin
            out_load  = out_free;
            out_range = mac_result;
            out_filt  = 1'b1;
            out_last  = end_ff && h_eff == '0;
         end
         sfs_pkg::ST_RAW: begin
            rd_addr  = IDX_W'(h_eff);
            out_load = out_free;
            out_last = end_ff && h_eff == '0;
         end
         sfs_pkg::ST_FLUSH: begin
            out_load = out_free;
            out_last = a_ff == '0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Counter and fill updates.
   always_comb begin
      idx_in        = idx_ff;
      a_in          = a_ff;
      fill_count_in = fill_count_ff;
      if (state_ff == sfs_pkg::ST_IDLE) begin
         idx_in = '0;
      end else if (state_ff == sfs_pkg::ST_MAC && !idx_last) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (accept) begin
         // short scan: the tail starts at the oldest entry of the scan, below the half width
         a_in = IDX_W'(fill_count_ff);
         if (req_scan_end) begin
            fill_count_in = '0;
         end else if (int'(fill_count_ff) < MAX_TAPS) begin
            fill_count_in = fill_count_ff + CNT_W'(1);
         end
      end else if (out_load) begin
         if (state_ff == sfs_pkg::ST_FLUSH) begin
            a_in = a_ff - IDX_W'(1);
         end else begin
            a_in = IDX_W'(h_eff - CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfs_pkg::ST_IDLE;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // advance the window, newest sample at entry 0
         if (accept) begin
            for (int i = MAX_TAPS - 1; i > 0; i--) begin
               window_ff[i] <= window_ff[i-1];
            end
            window_ff[0] <= req_range_in;
         end
      end
      idx_ff <= idx_in;
      a_ff   <= a_in;
      if (accept) begin
         end_ff <= req_scan_end;
      end
      if (out_load) begin
         rsp_range_ff <= out_range;
         rsp_filt_ff  <= out_filt;
         rsp_last_ff  <= out_last;
      end
   end

   sfs_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_TAPS    (MAX_TAPS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (win_rd),
      .coef   (coef_ff[sfs_pkg::COEF_IDX_W'(idx_ff)]),
      .result (mac_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_range_out    = rsp_range_ff;
   assign rsp_was_filtered = rsp_filt_ff;
   assign rsp_scan_last    = rsp_last_ff;

endmodule

### rtl/sfs_checker.sv
// Port-level assertions for scan_fir_smoother_core, attached by bind.
// Depends on scan_fir_smoother_core.
module sfs_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_scan_end,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_range_out,
   input logic                   rsp_was_filtered,
   input logic                   rsp_scan_last
);

   // Reset leaves the block idle with nothing to deliver.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // A held result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_out)
         && $stable(rsp_was_filtered) && $stable(rsp_scan_last))
      else $error("stalled result changed");

   // A scan end always produces at least one result, so the block goes busy.
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_scan_end |=> !req_ready)
      else $error("scan end accepted without going busy");

   // An idle block with an empty output register shows nothing in the next cycle.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_ready |=> !rsp_valid)
      else $error("result appeared straight out of idle");

endmodule

bind scan_fir_smoother_core sfs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sfs_checker (.*);

### sim/scan_fir_smoother_core_test.sv
// Self-checking testbench for scan_fir_smoother_core: directed and random scans,
// predicted per accepted item and compared against every result item.
// Depends on sfs_pkg and the RTL of scan_fir_smoother_core.
module scan_fir_smoother_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS  = 16;
   localparam int MAX_TAPS     = 7;
   localparam int DRAIN_CYCLES = 30;      // covers a filtered item plus a full flush
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_STALL   = 80;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] range_in;
      logic                   scan_end;
   } scan_sample_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] range_out;
      logic                   was_filtered;
      logic                   scan_last;
   } smoothed_type;

   // DUT signals, inputs driven to known values from time zero
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [SAMPLE_BITS-1:0]          req_range_in = '0;
   logic                            req_scan_end = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0]          rsp_range_out;
   logic                            rsp_was_filtered;
   logic                            rsp_scan_last;
   logic                            csr_wr_en = 1'b0;
   logic [sfs_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [sfs_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   // Shadow of the register file and of the block's sample history
   logic [sfs_pkg::TAP_W-1:0]         tap_setting;
   logic signed [sfs_pkg::COEF_W-1:0] weight_setting [sfs_pkg::NUM_COEF];
   logic [SAMPLE_BITS-1:0]            scan_window [MAX_TAPS];
   int unsigned                       samples_seen;

   scan_sample_type pending_samples [$];
   scan_sample_type staged_samples [$];
   smoothed_type    expected_ranges [$];
   logic [sfs_pkg::COEF_W-1:0] staged_weights [sfs_pkg::NUM_COEF];

   int  send_idle_pct = 29;
   int  recv_idle_pct = 86;
   bit  req_taken = 1'b0;
   bit  long_stall_go = 1'b0;
   int  error_count = 0;
   int  cycle_count = 0;

   int phase_taps   [9] = '{3, 5, 7, 0, 2, 4, 6, 1, 7};
   int phase_styles [9] = '{0, 1, 0, 2, 1, 0, 2, 0, 1};

   scan_fir_smoother_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_range_in     (req_range_in),
      .req_scan_end     (req_scan_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_range_out    (rsp_range_out),
      .rsp_was_filtered (rsp_was_filtered),
      .rsp_scan_last    (rsp_scan_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Mask length in use: clip to the window depth, round even counts down,
   // treat zero as a single tap.
   function automatic int mask_len();
      int t = int'(tap_setting);
      if (t > MAX_TAPS) t = MAX_TAPS;
      if (t % 2 == 0) t = (t == 0) ? 1 : t - 1;
      return t;
   endfunction

   // Exact sum of sample times weight, tap 0 on the oldest sample; round half
   // up at bit 15, then clamp into the unsigned sample range.
   function automatic logic [SAMPLE_BITS-1:0] mask_sum(int t);
      longint acc = 0;
      for (int i = 0; i < t; i++)
         acc += longint'(weight_setting[i]) * longint'(scan_window[t - 1 - i]);
      acc += sfs_pkg::ROUND_HALF;
      if (acc < 0) return '0;
      acc = acc >>> sfs_pkg::FRAC_BITS;
      if (acc > longint'({SAMPLE_BITS{1'b1}})) return '1;
      return acc[SAMPLE_BITS-1:0];
   endfunction

   function automatic void push_expected(logic [SAMPLE_BITS-1:0] value, logic filt,
                                         logic last);
      smoothed_type item;
      item.range_out    = value;
      item.was_filtered = filt;
      item.scan_last    = last;
      expected_ranges = {expected_ranges, item};
   endfunction

   // Advance the window by one accepted item and queue the items it releases.
   function automatic void predict_scan_sample(logic [SAMPLE_BITS-1:0] sample,
                                               logic last_in_scan);
      int t    = mask_len();
      int h    = t / 2;
      int k    = int'(samples_seen);
      int top;
      for (int i = MAX_TAPS - 1; i > 0; i--) scan_window[i] = scan_window[i - 1];
      scan_window[0] = sample;
      if (k >= h) begin
         if (k + 1 >= t)
            push_expected(mask_sum(t), 1'b1, last_in_scan && (h == 0));
         else
            push_expected(scan_window[h], 1'b0, last_in_scan && (h == 0));
      end
      if (last_in_scan) begin
         // flush the raw tail, oldest first
         top = (k >= h) ? h - 1 : k;
         for (int a = top; a >= 0; a--)
            push_expected(scan_window[a], 1'b0, a == 0);
         samples_seen = 0;
      end else begin
         samples_seen = (k + 1 > MAX_TAPS) ? MAX_TAPS : k + 1;
      end
   endfunction

   function automatic void reset_prediction();
      tap_setting = sfs_pkg::TAP_COUNT_RST;
      for (int i = 0; i < sfs_pkg::NUM_COEF; i++) weight_setting[i] = '0;
      weight_setting[0] = sfs_pkg::COEF0_RST;
      for (int i = 0; i < MAX_TAPS; i++) scan_window[i] = '0;
      samples_seen = 0;
   endfunction

   // ---------------------------------------------------------------------
   // Input driver: change at the falling edge, note acceptance at the rising
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_valid && req_ready) begin
         req_taken = 1'b1;
         predict_scan_sample(req_range_in, req_scan_end);
      end
   end

   always @(negedge clock) begin
      scan_sample_type next_item;
      // hold the current item until it is taken; only then pick the next one
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending_samples.pop_front();
            req_valid    <= 1'b1;
            req_range_in <= next_item.range_in;
            req_scan_end <= next_item.scan_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: random back-pressure plus one long hold-off
   // ---------------------------------------------------------------------
   int stall_left = 0;
   bit stall_started = 1'b0;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (long_stall_go && !stall_started) begin
         // hold off long enough for the output register to fill and stall req_ready
         stall_started = 1'b1;
         stall_left = LONG_STALL - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result item with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      smoothed_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ranges.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("cycle %0d: result with nothing expected: range %0d filt %0b last %0b",
                        cycle_count, rsp_range_out, rsp_was_filtered, rsp_scan_last);
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_range_out !== want.range_out || rsp_was_filtered !== want.was_filtered ||
                rsp_scan_last !== want.scan_last) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("cycle %0d: mismatch range %0d/%0d filt %0b/%0b last %0b/%0b %s",
                           cycle_count, want.range_out, rsp_range_out, want.was_filtered,
                           rsp_was_filtered, want.scan_last, rsp_scan_last,
                           "(expected/actual)");
            end
         end
      end
   end

   // Watchdog: end the run if it hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Register writes and stimulus helpers
   // ---------------------------------------------------------------------

   // Write one register and update the shadow copy; the caller must keep the block idle, which the task does not check.
   task automatic write_csr(input logic [sfs_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [sfs_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx == sfs_pkg::CSR_TAP_COUNT)
         tap_setting = data[sfs_pkg::TAP_W-1:0];
      else
         weight_setting[idx - sfs_pkg::CSR_COEF_BASE] = signed'(data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_config(input int taps);
      write_csr(sfs_pkg::CSR_TAP_COUNT, sfs_pkg::CSR_DATA_W'(taps));
      for (int i = 0; i < sfs_pkg::NUM_COEF; i++)
         write_csr(sfs_pkg::CSR_COEF_BASE + sfs_pkg::CSR_IDX_W'(i), staged_weights[i]);
   endtask

   task automatic fill_weights(input logic [sfs_pkg::COEF_W-1:0] value);
      for (int i = 0; i < sfs_pkg::NUM_COEF; i++) staged_weights[i] = value;
   endtask

   // Style 0: positive smoothing masks, 1: any signed weight, 2: extremes and zero
   task automatic pick_weights(input int style);
      for (int i = 0; i < sfs_pkg::NUM_COEF; i++) begin
         case (style)
            0: staged_weights[i] = sfs_pkg::COEF_W'($urandom_range(0, 12000));
            1: staged_weights[i] = sfs_pkg::COEF_W'($urandom);
            default: begin
               case ($urandom_range(2))
                  0: staged_weights[i] = 16'h8000;
                  1: staged_weights[i] = 16'h7FFF;
                  default: staged_weights[i] = 16'h0000;
               endcase
            end
         endcase
      end
   endtask

   task automatic stage_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
      scan_sample_type item;
      item.range_in = value;
      item.scan_end = last;
      staged_samples = {staged_samples, item};
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_range(int kind);
      case (kind)
         0: return SAMPLE_BITS'($urandom_range(0, 255));
         1: return SAMPLE_BITS'(65535 - $urandom_range(0, 255));
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // One well-formed scan: mostly typical lengths, some shorter than the longest mask,
   // some long enough to saturate the fill count.
   task automatic stage_scan();
      int sel = $urandom_range(99);
      int len;
      int scan_kind = $urandom_range(3);
      int kind;
      if (sel < 15) len = $urandom_range(1, 3);
      else if (sel < 85) len = $urandom_range(4, 12);
      else len = $urandom_range(13, 24);
      for (int i = 0; i < len; i++) begin
         kind = ($urandom_range(99) < 70) ? scan_kind : $urandom_range(2);
         stage_sample(pick_range(kind), i == len - 1);
      end
   endtask

   // Hand the staged items to the driver in one time step.
   task automatic release_staged();
      pending_samples = {pending_samples, staged_samples};
      staged_samples.delete();
   endtask

   // Wait until every item is taken and every result has come, then let the
   // block finish any item that releases no result.
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_ranges.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset_prediction();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: one tap of nearly unity weight, field extremes
      stage_sample(16'd0, 1'b0);
      stage_sample(16'hFFFF, 1'b0);
      stage_sample(16'd1, 1'b1);
      release_staged();
      wait_drained();

      // Half weight on one tap: exact ties round upward
      fill_weights(16'h0000);
      staged_weights[0] = 16'd16384;
      load_config(1);
      stage_sample(16'd1, 1'b0);
      stage_sample(16'd3, 1'b0);
      stage_sample(16'hFFFF, 1'b1);
      release_staged();
      wait_drained();

      // Full mask of maximum weights: saturate high; then a scan shorter than
      // the mask and a single-sample scan, both passed through raw
      fill_weights(16'h7FFF);
      load_config(7);
      for (int i = 0; i < 7; i++) stage_sample(16'hFFFF, i == 6);
      stage_sample(16'hFFFF, 1'b0);
      stage_sample(16'h8001, 1'b1);
      stage_sample(16'd12345, 1'b1);
      release_staged();
      wait_drained();

      // Most negative weights: the sum goes below zero and clamps to zero
      fill_weights(16'h8000);
      load_config(7);
      for (int i = 0; i < 7; i++) stage_sample(pick_range(2), i == 6);
      release_staged();
      wait_drained();

      // Zero tap count acts as a single tap
      fill_weights(16'h0000);
      staged_weights[0] = 16'h7FFF;
      load_config(0);
      stage_sample(16'hA5A5, 1'b0);
      stage_sample(16'h5A5A, 1'b1);
      release_staged();
      wait_drained();

      // Random phases: receiver-heavy idling, then sender-heavy, then none.
      // Odd phases leave the last scan open so the next tap count lands mid-scan.
      for (int p = 0; p < 9; p++) begin
         if (p < 3) begin
            send_idle_pct = 29;
            recv_idle_pct = 86;
         end else if (p < 6) begin
            send_idle_pct = 86;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick_weights(phase_styles[p]);
         load_config(phase_taps[p]);
         while (staged_samples.size() < 21) stage_scan();
         if (p % 2 == 1)
            staged_samples[staged_samples.size() - 1].scan_end = 1'b0;
         release_staged();
         if (p == 6) long_stall_go = 1'b1;
         wait_drained();
      end

      if (error_count == 0 && expected_ranges.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
rtl/sfs_pkg.sv
rtl/sfs_mac.sv
rtl/scan_fir_smoother_core.sv
rtl/sfs_checker.sv
sim/scan_fir_smoother_core_test.sv
